// ===== rtl/isort_pkg.sv =====
// Shared types and sizing constants for the insertion sorter.
package isort_pkg;

  localparam int MAX_ITEMS = 16;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W     = $clog2(MAX_ITEMS);

  typedef logic signed [DATA_W-1:0] data_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic shift;
  } isort_ctl_t;

endpackage

// ===== rtl/isort_cell.sv =====
// One cell of the insertion chain: holds a single sorted entry.
module isort_cell import isort_pkg::*; (
  input  logic       clk,
  input  isort_ctl_t ctl,
  input  data_t      value_new,
  input  data_t      left_val,
  input  logic       left_gt,
  input  data_t      right_val,
  input  logic       occ,
  output data_t      val,
  output logic       gt
);

  data_t val_next;

  // an empty cell counts as larger than any incoming word; equal stays put
  assign gt = !occ || (value_new < val);

  // make room by taking the left entry, or take the new word at the boundary
  always_comb begin
    val_next = val;
    if (ctl.insert) begin
      if (gt) begin
        val_next = left_gt ? left_val : value_new;
      end
    end else if (ctl.shift) begin
      val_next = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

// ===== rtl/insertion_sorter_core.sv =====
// Insertion sorter: a chain of cells that keeps incoming words in sorted order.
//
// Input channel (in_valid / in_stall, value_in, last_in): one signed word per
// cycle while a set is being collected. The word marked last ends the set.
// Output channel (out_valid / out_stall, value_out, last_out, overflow): the
// whole set in sorted order, last_out on its final word, overflow on every
// word of a set in which words beyond the chain length were dropped.
// cfg_wr_en / cfg_wr_data write the descending bit (1 = largest first).
// Throughput: one input word per cycle, set by the compare and shift in every
// cell. After the last word, in_stall is raised while the set drains: the
// drain flag and then the output register lie between the last word taken and
// the first result, then one result per cycle while the receiver does not stall.
// in_stall drops as the final result enters the output register.
// A stall from the receiver holds the output register and pauses the drain.
// Reset (rst, synchronous) empties the chain, clears the overflow flag and the
// descending bit; the stored entries themselves are not cleared.
module insertion_sorter_core import isort_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  data_t value_in,
  input  logic  last_in,
  output logic  out_valid,
  input  logic  out_stall,
  output data_t value_out,
  output logic  last_out,
  output logic  overflow,
  input  logic  cfg_wr_en,
  input  logic  cfg_wr_data
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             draining;
  logic             dropped;
  logic             descending;

  data_t            cell_val [MAX_ITEMS];
  logic             cell_gt  [MAX_ITEMS];
  logic             cell_occ [MAX_ITEMS];
  isort_ctl_t       ctl;

  logic             in_acc;
  logic             full;
  logic             load_out;
  logic             drain_end;
  logic [IDX_W-1:0] top_idx;
  logic [CNT_W-1:0] count_dec;

  assign in_stall  = draining;
  assign in_acc    = in_valid && !in_stall;
  assign full      = (count == CNT_W'(MAX_ITEMS));
  assign load_out  = draining && (!out_valid || !out_stall);
  assign drain_end = load_out && (count == CNT_W'(1));
  assign count_dec = count - CNT_W'(1);
  assign top_idx   = count_dec[IDX_W-1:0];

  assign ctl.insert = in_acc && !full;
  assign ctl.shift  = load_out && !descending;

  // chain of cells, lowest entry in cell zero
  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    data_t left_val;
    logic  left_gt;
    data_t right_val;

    assign cell_occ[g] = (count > CNT_W'(g));

    if (g == 0) begin : g_head
      assign left_val = value_in;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_val = cell_val[g-1];
      assign left_gt  = cell_gt[g-1];
    end

    if (g == MAX_ITEMS - 1) begin : g_tail
      assign right_val = cell_val[g];
    end else begin : g_body
      assign right_val = cell_val[g+1];
    end

    isort_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .value_new (value_in),
      .left_val  (left_val),
      .left_gt   (left_gt),
      .right_val (right_val),
      .occ       (cell_occ[g]),
      .val       (cell_val[g]),
      .gt        (cell_gt[g])
    );
  end

  // fill count: grow on insert, shrink per drained word
  always_comb begin
    count_next = count;
    if (ctl.insert) begin
      count_next = count + CNT_W'(1);
    end else if (load_out) begin
      count_next = count_dec;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      draining   <= 1'b0;
      dropped    <= 1'b0;
      descending <= 1'b0;
    end else begin
      count <= count_next;
      if (cfg_wr_en) begin
        descending <= cfg_wr_data;
      end
      if (in_acc && last_in) begin
        draining <= 1'b1;
      end else if (drain_end) begin
        draining <= 1'b0;
      end
      if (in_acc && full) begin
        dropped <= 1'b1;
      end else if (drain_end) begin
        dropped <= 1'b0;
      end
    end
  end

  // output register: hold while stalled, load the next sorted word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      value_out <= descending ? cell_val[top_idx] : cell_val[0];
      last_out  <= (count == CNT_W'(1));
      overflow  <= dropped;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ITEMS))
    else $error("fill count beyond chain length");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    draining |-> (count != '0))
    else $error("draining with an empty chain");

  a_drop_flags: assert property (@(posedge clk) disable iff (rst)
    (in_acc && full) |=> dropped)
    else $error("dropped word not flagged");

  a_drain_order: assert property (@(posedge clk) disable iff (rst)
    (load_out && !descending && count > CNT_W'(1)) |=> (cell_val[0] == $past(cell_val[1])))
    else $error("chain did not advance on drain");
`endif

endmodule
